// ----- sv/hmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_pkg
// Shared types and codes of the histogram median filter: register indexes,
// controller states, datapath operations and the command/status bundles.
// ----------------------------------------------------------------------------
package hmf_pkg;

  // bins per column-histogram word
  localparam int LANES  = 8;
  localparam int LANE_W = 3;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;

  typedef enum logic [1:0] {PH_IDLE, PH_RECV, PH_DRAIN} phase_t;

  typedef enum logic [4:0] {
    S_WAIT, S_CLEAR, S_UPD_PREP, S_OLD_RD, S_OLD_HRD, S_DEC, S_NEW_RD, S_INC,
    S_CHECK, S_PIX_END, S_DROP_INIT, S_DROP_LS, S_DROP_HRD, S_DROP_DEC,
    S_KER_INIT, S_KER_RD, S_KER_ACC, S_SRCH_INIT, S_SRCH_RD, S_SRCH_CHK,
    S_ADV, S_PUSH
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_LOAD, OP_CLEAR, OP_PREP_PIX, OP_PREP_DROP, OP_OLD_RD,
    OP_OLD_HIST_RD, OP_HIST_DEC, OP_DROP_DEC, OP_NEW_RD, OP_HIST_INC,
    OP_PIX_END, OP_KER_INIT, OP_KER_RD, OP_KER_ACC, OP_SRCH_INIT, OP_SRCH_RD,
    OP_SRCH_CHK, OP_ADV, OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic row_full;
    logic emit_ok;
    logic drop_needed;
    logic out_done;
    logic frame_last_pix;
    logic cp_last;
    logic wd_last;
    logic cp_end;
    logic hit;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- sv/hmf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_datapath
// Line store, column histograms, kernel histogram, frame counters, rank
// search and the output register, driven one operation per cycle.
// ----------------------------------------------------------------------------
module hmf_datapath #(
  parameter int BINS       = 256,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  hmf_pkg::dp_cmd_t   cmd,
  output hmf_pkg::dp_status_t status,
  input  logic               write_enable,
  input  logic [1:0]         write_index,
  input  logic [15:0]        write_data,
  input  logic [7:0]         pixel_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         median_value,
  output logic               last_of_run,
  output logic               end_of_frame
);
  import hmf_pkg::*;

  localparam int LINE_ROWS = 2 * MAX_RADIUS + 1;
  localparam int BIN_W     = $clog2(BINS);
  localparam int XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCW       = $clog2(MAX_WIDTH + 1);
  localparam int NWORDS    = (BINS + LANES - 1) / LANES;
  localparam int WW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int RW        = $clog2(LINE_ROWS);
  localparam int RADW      = $clog2(MAX_RADIUS + 1);
  localparam int CW        = $clog2(LINE_ROWS + 1);
  localparam int KW        = $clog2(LINE_ROWS * LINE_ROWS + 1);
  localparam int HIST_AW   = XW + WW;
  localparam int LS_AW     = RW + XW;

  // configuration
  logic [2:0]  cfg_radius;
  logic [10:0] cfg_width;
  logic [15:0] cfg_height;

  // frame settings latched at the first pixel
  logic [RADW-1:0] act_r;
  logic [WCW-1:0]  act_w;
  logic [15:0]     act_h;

  logic [15:0]     y, oy;
  logic [XW-1:0]   x, ox, cp;
  logic [RW-1:0]   lrow, oymod, ls_row;
  logic [WW-1:0]   wd;
  logic [BIN_W-1:0] pix_bin, old_bin, med;
  logic            eof_r;

  logic [KW-1:0]   n, cum, thr;
  logic [LANES-1:0][KW-1:0] acc;

  logic [LANES-1:0][CW-1:0] hist_mem [2**HIST_AW];
  logic [LANES-1:0][CW-1:0] hist_q, hist_wd;
  logic [HIST_AW-1:0]       hist_wa, hist_ra;
  logic                     hist_we;

  logic [BIN_W-1:0] ls_mem [2**LS_AW];
  logic [BIN_W-1:0] ls_q;
  logic             ls_we;

  logic [LANES-1:0][KW-1:0] k_mem [NWORDS];
  logic [LANES-1:0][KW-1:0] kq;
  logic                     k_we;

  logic [LANES-1:0][KW-1:0] acc_sum;
  logic [KW-1:0]            acc_tot, ksum;
  logic                     hit;
  logic [LANE_W-1:0]        hit_lane;
  logic [XW-1:0]            c0;
  logic [RW-1:0]            drop_slot;

  function automatic logic [WW-1:0] word_of(input logic [BIN_W-1:0] b);
    return WW'(int'(b) / LANES);
  endfunction

  function automatic logic [LANE_W-1:0] lane_of(input logic [BIN_W-1:0] b);
    return LANE_W'(int'(b) % LANES);
  endfunction

  // frame geometry and loop status
  always_comb begin
    int r, k, wm1, ry, rx, c0i, ds;
    r   = int'(act_r);
    k   = 2 * r + 1;
    wm1 = int'(act_w) - 1;
    ry  = int'(oy) + r;
    rx  = (int'(ox) + r < wm1) ? int'(ox) + r : wm1;
    c0i = (int'(ox) >= r) ? int'(ox) - r : 0;
    ds  = int'(oymod) + r;
    c0        = XW'(c0i);
    drop_slot = RW'((ds >= k) ? ds - k : ds);
    status.row_full       = int'(y) >= k;
    status.emit_ok        = (int'(oy) < int'(act_h)) && !(ry > int'(y)) &&
                            !(ry == int'(y) && rx > int'(x));
    status.drop_needed    = (ox == '0) && (int'(oy) >= r + 1);
    status.out_done       = int'(oy) >= int'(act_h);
    status.frame_last_pix = (int'(y) == int'(act_h) - 1) && (int'(x) == wm1);
    status.cp_last        = int'(cp) == wm1;
    status.wd_last        = int'(wd) == NWORDS - 1;
    status.cp_end         = int'(cp) == rx;
    status.hit            = hit;
    status.out_busy       = out_valid && !out_ready;
  end

  // kernel accumulation and rank search over one word
  always_comb begin
    logic [KW-1:0] run;
    acc_tot  = '0;
    ksum     = '0;
    hit      = 1'b0;
    hit_lane = '0;
    run      = cum;
    for (int l = 0; l < LANES; l++) begin
      acc_sum[l] = acc[l] + KW'(hist_q[l]);
      acc_tot    = acc_tot + acc_sum[l];
      ksum       = ksum + kq[l];
      run        = run + kq[l];
      if (!hit && run >= thr) begin
        hit      = 1'b1;
        hit_lane = LANE_W'(l);
      end
    end
  end

  // memory port selection
  always_comb begin
    hist_we = 1'b0;
    hist_wa = {cp, wd};
    hist_ra = {cp, wd};
    hist_wd = '0;
    ls_we   = 1'b0;
    k_we    = 1'b0;
    unique case (cmd.op)
      OP_OLD_HIST_RD: hist_ra = {cp, word_of(ls_q)};
      OP_HIST_DEC, OP_DROP_DEC: begin
        hist_we = 1'b1;
        hist_wa = {cp, word_of(old_bin)};
        hist_wd = hist_q;
        if (hist_q[lane_of(old_bin)] != '0) begin
          hist_wd[lane_of(old_bin)] = hist_q[lane_of(old_bin)] - 1'b1;
        end
      end
      OP_NEW_RD: begin
        ls_we   = 1'b1;
        hist_ra = {cp, word_of(pix_bin)};
      end
      OP_HIST_INC: begin
        hist_we = 1'b1;
        hist_wa = {cp, word_of(pix_bin)};
        hist_wd = hist_q;
        hist_wd[lane_of(pix_bin)] = hist_q[lane_of(pix_bin)] + 1'b1;
      end
      OP_CLEAR:   hist_we = 1'b1;
      OP_KER_ACC: k_we = status.cp_end;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_q <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[{ls_row, cp}] <= pix_bin;
    end
    ls_q <= ls_mem[{ls_row, cp}];
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      k_mem[wd] <= acc_sum;
    end
    kq <= k_mem[wd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_radius <= 3'd1;
      cfg_width  <= 11'd1024;
      cfg_height <= 16'd1024;
    end else if (write_enable) begin
      unique case (write_index)
        REG_RADIUS: cfg_radius <= write_data[2:0];
        REG_WIDTH:  cfg_width  <= write_data[10:0];
        REG_HEIGHT: cfg_height <= write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_START: begin
        act_r <= RADW'((int'(cfg_radius) > MAX_RADIUS) ? MAX_RADIUS : int'(cfg_radius));
        act_w <= WCW'((cfg_width == '0) ? 1 :
                      ((int'(cfg_width) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width)));
        act_h <= (cfg_height == '0) ? 16'd1 : cfg_height;
        y     <= '0;
        x     <= '0;
        oy    <= '0;
        ox    <= '0;
        lrow  <= '0;
        oymod <= '0;
        cp    <= '0;
        wd    <= '0;
        pix_bin <= BIN_W'((int'(pixel_value) >= BINS - 1) ? BINS - 1 : int'(pixel_value));
      end
      OP_LOAD: begin
        pix_bin <= BIN_W'((int'(pixel_value) >= BINS - 1) ? BINS - 1 : int'(pixel_value));
      end
      OP_CLEAR: begin
        if (status.wd_last) begin
          wd <= '0;
          cp <= cp + 1'b1;
        end else begin
          wd <= wd + 1'b1;
        end
      end
      OP_PREP_PIX: begin
        cp     <= x;
        ls_row <= lrow;
      end
      OP_PREP_DROP: begin
        cp     <= '0;
        ls_row <= drop_slot;
      end
      OP_OLD_HIST_RD: old_bin <= ls_q;
      OP_DROP_DEC:    cp <= cp + 1'b1;
      OP_PIX_END: begin
        if (int'(x) == int'(act_w) - 1) begin
          x    <= '0;
          y    <= y + 1'b1;
          lrow <= (int'(lrow) + 1 == 2 * int'(act_r) + 1) ? '0 : lrow + 1'b1;
        end else begin
          x <= x + 1'b1;
        end
      end
      OP_KER_INIT: begin
        wd  <= '0;
        cp  <= c0;
        n   <= '0;
        acc <= '0;
      end
      OP_KER_ACC: begin
        if (status.cp_end) begin
          n   <= n + acc_tot;
          acc <= '0;
          cp  <= c0;
          wd  <= wd + 1'b1;
        end else begin
          acc <= acc_sum;
          cp  <= cp + 1'b1;
        end
      end
      OP_SRCH_INIT: begin
        wd  <= '0;
        cum <= '0;
        thr <= (n >> 1) + KW'(1);
      end
      OP_SRCH_CHK: begin
        if (hit) begin
          med <= BIN_W'(int'(wd) * LANES + int'(hit_lane));
        end else begin
          cum <= cum + ksum;
          wd  <= wd + 1'b1;
          if (status.wd_last) begin
            med <= BIN_W'(BINS - 1);
          end
        end
      end
      OP_ADV: begin
        eof_r <= (int'(oy) == int'(act_h) - 1) && (int'(ox) == int'(act_w) - 1);
        if (int'(ox) == int'(act_w) - 1) begin
          ox    <= '0;
          oy    <= oy + 1'b1;
          oymod <= (int'(oymod) + 1 == 2 * int'(act_r) + 1) ? '0 : oymod + 1'b1;
        end else begin
          ox <= ox + 1'b1;
        end
      end
      OP_PUSH: begin
        median_value <= 8'(int'(med));
        last_of_run  <= cmd.last;
        end_of_frame <= eof_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_PUSH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- sv/hmf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_ctrl
// Sequencer of the median filter: frame phase, per-pixel histogram update,
// row drop while draining, kernel build, rank search and result hand-off.
// ----------------------------------------------------------------------------
module hmf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  hmf_pkg::dp_status_t status,
  output hmf_pkg::dp_cmd_t    cmd
);
  import hmf_pkg::*;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   is_flush, is_flush_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_WAIT;
      phase    <= PH_IDLE;
      is_flush <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      is_flush <= is_flush_next;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    is_flush_next = is_flush;
    cmd.op        = OP_NONE;
    cmd.last      = 1'b0;
    in_ready      = 1'b0;
    unique case (state)
      S_WAIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          is_flush_next = req_type != REQ_PIXEL;
          if (req_type == REQ_PIXEL) begin
            if (phase == PH_IDLE) begin
              cmd.op     = OP_START;
              phase_next = PH_RECV;
              state_next = S_CLEAR;
            end else if (phase == PH_RECV) begin
              cmd.op     = OP_LOAD;
              state_next = S_UPD_PREP;
            end
            // drop pixels while draining
          end else if (phase == PH_DRAIN) begin
            state_next = status.drop_needed ? S_DROP_INIT : S_KER_INIT;
          end
        end
      end
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.cp_last && status.wd_last) begin
          state_next = S_UPD_PREP;
        end
      end
      S_UPD_PREP: begin
        cmd.op     = OP_PREP_PIX;
        state_next = status.row_full ? S_OLD_RD : S_NEW_RD;
      end
      S_OLD_RD: begin
        cmd.op     = OP_OLD_RD;
        state_next = S_OLD_HRD;
      end
      S_OLD_HRD: begin
        cmd.op     = OP_OLD_HIST_RD;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.op     = OP_HIST_DEC;
        state_next = S_NEW_RD;
      end
      S_NEW_RD: begin
        cmd.op     = OP_NEW_RD;
        state_next = S_INC;
      end
      S_INC: begin
        cmd.op     = OP_HIST_INC;
        state_next = S_CHECK;
      end
      S_CHECK: state_next = status.emit_ok ? S_KER_INIT : S_PIX_END;
      S_PIX_END: begin
        cmd.op = OP_PIX_END;
        if (status.frame_last_pix) begin
          phase_next = status.out_done ? PH_IDLE : PH_DRAIN;
        end
        state_next = S_WAIT;
      end
      S_DROP_INIT: begin
        cmd.op     = OP_PREP_DROP;
        state_next = S_DROP_LS;
      end
      S_DROP_LS: begin
        cmd.op     = OP_OLD_RD;
        state_next = S_DROP_HRD;
      end
      S_DROP_HRD: begin
        cmd.op     = OP_OLD_HIST_RD;
        state_next = S_DROP_DEC;
      end
      S_DROP_DEC: begin
        cmd.op     = OP_DROP_DEC;
        state_next = status.cp_last ? S_KER_INIT : S_DROP_LS;
      end
      S_KER_INIT: begin
        cmd.op     = OP_KER_INIT;
        state_next = S_KER_RD;
      end
      S_KER_RD: begin
        cmd.op     = OP_KER_RD;
        state_next = S_KER_ACC;
      end
      S_KER_ACC: begin
        cmd.op     = OP_KER_ACC;
        state_next = (status.cp_end && status.wd_last) ? S_SRCH_INIT : S_KER_RD;
      end
      S_SRCH_INIT: begin
        cmd.op     = OP_SRCH_INIT;
        state_next = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        cmd.op     = OP_SRCH_RD;
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        cmd.op     = OP_SRCH_CHK;
        state_next = (status.hit || status.wd_last) ? S_ADV : S_SRCH_RD;
      end
      S_ADV: begin
        cmd.op     = OP_ADV;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (!status.out_busy) begin
          cmd.op   = OP_PUSH;
          cmd.last = is_flush || !status.emit_ok;
          if (is_flush) begin
            if (status.out_done) begin
              phase_next = PH_IDLE;
            end
            state_next = S_WAIT;
          end else begin
            state_next = status.emit_ok ? S_KER_INIT : S_PIX_END;
          end
        end
      end
      default: state_next = S_WAIT;
    endcase
  end

  a_push_space: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUSH) |-> !status.out_busy)
    else $error("result pushed into a stalled output register");

  a_clear_recv: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (phase == PH_RECV && !is_flush))
    else $error("histogram clear outside frame start");

  a_drop_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_DROP_INIT) |-> (phase == PH_DRAIN && is_flush))
    else $error("row drop outside draining");

  a_pix_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX_END) |-> (!is_flush && phase == PH_RECV))
    else $error("pixel step finished on a flush transaction");

endmodule

// ----- sv/histogram_median_filter_2d.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_median_filter_2d
// Streaming 2-D median filter over a clipped square window, built on
// per-column histograms and a cumulative bin search.
// ----------------------------------------------------------------------------
// Usage: pixels enter in raster order on in_valid/in_ready (req_type 0);
// after the last pixel, flush transactions (req_type 1) drain the remaining
// rows, one result each. Results leave on out_valid/out_ready in raster
// order; last_of_run marks the final result of a transaction, end_of_frame
// the result of the frame's last pixel. Radius, width and height are taken
// at a frame's first pixel.
// Operation: a pixel update removes the leaving line's value from its column
// histogram, once the window is full, and adds the new pixel. Each result
// sums the clipped window columns into a kernel histogram of NW = BINS/8
// words and searches its cumulative counts for the median bin. A frame's first
// pixel first clears all column histograms; a drain row start drops a line.
// One transaction is in flight at a time; in_ready is low while it runs.
// Reset returns the block to idle with default registers. A stalled
// receiver holds the result register and the sequencer waits behind it.
// ----------------------------------------------------------------------------
module histogram_median_filter_2d #(
  parameter int BINS       = 256,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  pixel_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  median_value,
  output logic        last_of_run,
  output logic        end_of_frame,
  input  logic        write_enable,
  input  logic [1:0]  write_index,
  input  logic [15:0] write_data
);
  import hmf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  hmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  hmf_datapath #(
    .BINS       (BINS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixel_value  (pixel_value),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .median_value (median_value),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
  );

endmodule
